### src/crg_pkg.sv
`timescale 1ns / 1ps

package crg_pkg;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	localparam int MAX_SPANS = 8;
	localparam int IDX_BITS  = $clog2(MAX_SPANS);

	localparam logic [IDX_BITS-1:0] LAST_IDX_IDLE    = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] LAST_IDX_FILL    = IDX_BITS'(3);
	localparam logic [IDX_BITS-1:0] LAST_IDX_OUTLINE = IDX_BITS'(7);

	// Per-step flags handed from the circle state to the span emitter.
	typedef struct packed {
		logic fill;
		logic done;
		logic idle;
	} step_flags_t;

endpackage

### src/crg_if.sv
`timescale 1ns / 1ps

interface crg_req_if #(
	parameter int COORD_BITS  = 12,
	parameter int RADIUS_BITS = 10
);
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic signed [COORD_BITS-1:0]  center_x;
	logic signed [COORD_BITS-1:0]  center_y;
	logic        [RADIUS_BITS-1:0] radius;
	logic                          fill_mode;

	modport source (
		output valid, req_type, center_x, center_y, radius, fill_mode,
		input  ready
	);
	modport sink (
		input  valid, req_type, center_x, center_y, radius, fill_mode,
		output ready
	);
endinterface

interface crg_res_if #(
	parameter int COORD_BITS = 12
);
	logic                        valid;
	logic                        ready;
	logic signed [COORD_BITS:0]  span_start_x;
	logic signed [COORD_BITS:0]  span_end_x;
	logic signed [COORD_BITS:0]  row_y;
	logic                        last_of_step;
	logic                        circle_done;
	logic                        idle_flag;

	modport source (
		output valid, span_start_x, span_end_x, row_y, last_of_step, circle_done,
			idle_flag,
		input  ready
	);
	modport sink (
		input  valid, span_start_x, span_end_x, row_y, last_of_step, circle_done,
			idle_flag,
		output ready
	);
endinterface

### src/circle_raster_generator_core.sv
`timescale 1ns / 1ps

// Channel  Dir  Fields
// req      in   req_type, center_x, center_y, radius, fill_mode
// res      out  span_start_x, span_end_x, row_y, last_of_step, circle_done, idle_flag
//
// A step request yields 8 points (outline), 4 spans (fill) or 1 idle result,
// one per cycle from the output register; a start request yields none.
// The next request is taken in the cycle the last result of the held step
// enters the output register, so while res is ready there is no gap between
// steps. Reset clears the circle state to no circle active.
// A stall on res holds the output register and, behind it, the held step.
module circle_raster_generator_core import crg_pkg::*; #(
	parameter int COORD_BITS  = 12,
	parameter int RADIUS_BITS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	crg_req_if.sink   req,
	crg_res_if.source res
);

	localparam int OFF_BITS = RADIUS_BITS + 2;

	logic                         take_ok;
	logic                         accept;
	logic                         step_load;
	logic signed [COORD_BITS-1:0] cur_x;
	logic signed [COORD_BITS-1:0] cur_y;
	logic signed [OFF_BITS-1:0]   cur_ox;
	logic signed [OFF_BITS-1:0]   cur_oy;
	step_flags_t                  cur_flags;

	assign req.ready = take_ok;
	assign accept    = req.valid && take_ok;

	crg_state #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS),
		.OFF_BITS    (OFF_BITS)
	) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (req.req_type),
		.center_x  (req.center_x),
		.center_y  (req.center_y),
		.radius    (req.radius),
		.fill_mode (req.fill_mode),
		.step_load (step_load),
		.cur_x     (cur_x),
		.cur_y     (cur_y),
		.cur_ox    (cur_ox),
		.cur_oy    (cur_oy),
		.cur_flags (cur_flags)
	);

	crg_emit #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS),
		.OFF_BITS    (OFF_BITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_load (step_load),
		.cur_x     (cur_x),
		.cur_y     (cur_y),
		.cur_ox    (cur_ox),
		.cur_oy    (cur_oy),
		.cur_flags (cur_flags),
		.take_ok   (take_ok),
		.res       (res)
	);

endmodule

### src/crg_state.sv
`timescale 1ns / 1ps

module crg_state import crg_pkg::*; #(
	parameter int COORD_BITS  = 12,
	parameter int RADIUS_BITS = 10,
	parameter int OFF_BITS    = RADIUS_BITS + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          req_type,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic        [RADIUS_BITS-1:0] radius,
	input  logic                          fill_mode,
	output logic                          step_load,
	output logic signed [COORD_BITS-1:0]  cur_x,
	output logic signed [COORD_BITS-1:0]  cur_y,
	output logic signed [OFF_BITS-1:0]    cur_ox,
	output logic signed [OFF_BITS-1:0]    cur_oy,
	output step_flags_t                   cur_flags
);

	localparam int EW = RADIUS_BITS + 4;

	logic signed [COORD_BITS-1:0]  ctr_x_q;
	logic signed [COORD_BITS-1:0]  ctr_y_q;
	logic        [RADIUS_BITS-1:0] rad_q;
	logic signed [OFF_BITS-1:0]    off_x_q;
	logic signed [OFF_BITS-1:0]    off_y_q;
	logic signed [EW-1:0]          err_q;
	logic                          fill_q;
	logic                          busy_q;

	logic signed [EW-1:0]       e;
	logic signed [EW-1:0]       ox_e;
	logic signed [EW-1:0]       oy_e;
	logic signed [EW-1:0]       rad_e;
	logic signed [EW-1:0]       err_nxt;
	logic signed [OFF_BITS-1:0] ox_nxt;
	logic signed [OFF_BITS-1:0] oy_nxt;
	logic                       done;

	always_comb begin
		e     = err_q;
		ox_e  = EW'(off_x_q);
		oy_e  = EW'(off_y_q);
		rad_e = EW'({2'b00, rad_q});
		priority if (e >= (ox_e <<< 1)) begin
			err_nxt = e - (ox_e <<< 1) - EW'(1);
			ox_nxt  = OFF_BITS'(ox_e + EW'(1));
			oy_nxt  = off_y_q;
		end else if (e < ((rad_e - oy_e) <<< 1)) begin
			err_nxt = e + (oy_e <<< 1) - EW'(1);
			ox_nxt  = off_x_q;
			oy_nxt  = OFF_BITS'(oy_e - EW'(1));
		end else begin
			err_nxt = e + ((oy_e - ox_e - EW'(1)) <<< 1);
			ox_nxt  = OFF_BITS'(ox_e + EW'(1));
			oy_nxt  = OFF_BITS'(oy_e - EW'(1));
		end
		done = oy_nxt < ox_nxt;
	end

	assign step_load      = accept && (req_type == REQ_STEP);
	assign cur_x          = ctr_x_q;
	assign cur_y          = ctr_y_q;
	assign cur_ox         = off_x_q;
	assign cur_oy         = off_y_q;
	assign cur_flags.fill = fill_q;
	assign cur_flags.done = done;
	assign cur_flags.idle = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_x_q <= '0;
			ctr_y_q <= '0;
			rad_q   <= '0;
			off_x_q <= '0;
			off_y_q <= '0;
			err_q   <= '0;
			fill_q  <= 1'b0;
			busy_q  <= 1'b0;
		end else if (accept) begin
			if (req_type == REQ_START) begin
				ctr_x_q <= center_x;
				ctr_y_q <= center_y;
				rad_q   <= radius;
				off_x_q <= '0;
				off_y_q <= OFF_BITS'({2'b00, radius});
				err_q   <= EW'({2'b00, radius}) - EW'(1);
				fill_q  <= fill_mode;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				off_x_q <= ox_nxt;
				off_y_q <= oy_nxt;
				err_q   <= err_nxt;
				// drop the circle once the offsets cross
				if (done) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

### src/crg_emit.sv
`timescale 1ns / 1ps

module crg_emit import crg_pkg::*; #(
	parameter int COORD_BITS  = 12,
	parameter int RADIUS_BITS = 10,
	parameter int OFF_BITS    = RADIUS_BITS + 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_load,
	input  logic signed [COORD_BITS-1:0] cur_x,
	input  logic signed [COORD_BITS-1:0] cur_y,
	input  logic signed [OFF_BITS-1:0]   cur_ox,
	input  logic signed [OFF_BITS-1:0]   cur_oy,
	input  step_flags_t                  cur_flags,
	output logic                         take_ok,
	crg_res_if.source                    res
);

	localparam int CW = COORD_BITS + 1;
	localparam int SW = (CW > OFF_BITS + 1) ? CW : OFF_BITS + 1;

	logic                         rec_valid_q;
	logic signed [COORD_BITS-1:0] rec_x_q;
	logic signed [COORD_BITS-1:0] rec_y_q;
	logic signed [OFF_BITS-1:0]   rec_ox_q;
	logic signed [OFF_BITS-1:0]   rec_oy_q;
	step_flags_t                  rec_flags_q;
	logic [IDX_BITS-1:0]          idx_q;

	logic                         out_valid_q;
	logic signed [CW-1:0]         out_xs_q;
	logic signed [CW-1:0]         out_xe_q;
	logic signed [CW-1:0]         out_y_q;
	logic                         out_last_q;
	logic                         out_done_q;
	logic                         out_idle_q;

	logic signed [SW-1:0] xw, yw, oxw, oyw;
	logic signed [CW-1:0] xpo, xpy, xmo, xmy, ypo, ypy, ymo, ymy;
	logic signed [CW-1:0] nxt_xs, nxt_xe, nxt_y;
	logic [IDX_BITS-1:0]  last_idx;
	logic                 rec_last;
	logic                 out_load;

	always_comb begin
		xw  = SW'(rec_x_q);
		yw  = SW'(rec_y_q);
		oxw = SW'(rec_ox_q);
		oyw = SW'(rec_oy_q);
		xpo = CW'(xw + oxw);
		xpy = CW'(xw + oyw);
		xmo = CW'(xw - oxw);
		xmy = CW'(xw - oyw);
		ypo = CW'(yw + oxw);
		ypy = CW'(yw + oyw);
		ymo = CW'(yw - oxw);
		ymy = CW'(yw - oyw);
	end

	always_comb begin
		nxt_xs = '0;
		nxt_xe = '0;
		nxt_y  = '0;
		if (rec_flags_q.idle) begin
			nxt_xs = '0;
		end else if (rec_flags_q.fill) begin
			unique case (idx_q[1:0])
				2'd0: begin nxt_xs = xmy; nxt_xe = xpy; nxt_y = ypo; end
				2'd1: begin nxt_xs = xmo; nxt_xe = xpo; nxt_y = ypy; end
				2'd2: begin nxt_xs = xmo; nxt_xe = xpo; nxt_y = ymy; end
				2'd3: begin nxt_xs = xmy; nxt_xe = xpy; nxt_y = ymo; end
				default: begin nxt_xs = '0; end
			endcase
		end else begin
			unique case (idx_q)
				3'd0: begin nxt_xs = xpo; nxt_y = ypy; end
				3'd1: begin nxt_xs = xpy; nxt_y = ypo; end
				3'd2: begin nxt_xs = xmo; nxt_y = ypy; end
				3'd3: begin nxt_xs = xmy; nxt_y = ypo; end
				3'd4: begin nxt_xs = xpo; nxt_y = ymy; end
				3'd5: begin nxt_xs = xpy; nxt_y = ymo; end
				3'd6: begin nxt_xs = xmo; nxt_y = ymy; end
				3'd7: begin nxt_xs = xmy; nxt_y = ymo; end
				default: begin nxt_xs = '0; end
			endcase
			nxt_xe = nxt_xs;
		end
	end

	always_comb begin
		priority if (rec_flags_q.idle) begin
			last_idx = LAST_IDX_IDLE;
		end else if (rec_flags_q.fill) begin
			last_idx = LAST_IDX_FILL;
		end else begin
			last_idx = LAST_IDX_OUTLINE;
		end
	end

	assign rec_last = (idx_q == last_idx);
	assign out_load = rec_valid_q && (!out_valid_q || res.ready);
	assign take_ok  = !rec_valid_q || (out_load && rec_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
			idx_q       <= '0;
			rec_flags_q <= '0;
		end else begin
			if (step_load) begin
				rec_valid_q <= 1'b1;
				idx_q       <= '0;
				rec_flags_q <= cur_flags;
			end else if (out_load) begin
				// advance through the spans of the held step
				if (rec_last) begin
					rec_valid_q <= 1'b0;
				end
				idx_q <= idx_q + IDX_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_load) begin
			rec_x_q  <= cur_x;
			rec_y_q  <= cur_y;
			rec_ox_q <= cur_ox;
			rec_oy_q <= cur_oy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_xs_q   <= nxt_xs;
			out_xe_q   <= nxt_xe;
			out_y_q    <= nxt_y;
			out_last_q <= rec_last;
			out_done_q <= rec_flags_q.done && !rec_flags_q.idle;
			out_idle_q <= rec_flags_q.idle;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.span_start_x = out_xs_q;
	assign res.span_end_x   = out_xe_q;
	assign res.row_y        = out_y_q;
	assign res.last_of_step = out_last_q;
	assign res.circle_done  = out_done_q;
	assign res.idle_flag    = out_idle_q;

endmodule
